@@ rtl/obb_2d_sat_collision_unit_macros.svh @@
// Assertion macros used by the port-level checker file of the box overlap unit.
`ifndef OBB_2D_SAT_COLLISION_UNIT_MACROS_SVH
`define OBB_2D_SAT_COLLISION_UNIT_MACROS_SVH

// Plain clocked property, disabled while reset is asserted.
`define OBBSAT_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("obbsat check failed");

// Same-cycle implication.
`define OBBSAT_IMPLIES(label, ante, cons) \
    `OBBSAT_ASSERT(label, (ante) |-> (cons))

// Next-cycle implication.
`define OBBSAT_NEXT(label, ante, cons) \
    `OBBSAT_ASSERT(label, (ante) |=> (cons))

`endif

@@ rtl/obbsat_pkg.sv @@
// Types and fixed widths shared by the box overlap unit.
`timescale 1ns / 1ps
package obbsat_pkg;

    localparam int COORD_BITS   = 24;
    localparam int HALF_BITS    = COORD_BITS - 1;
    localparam int ROT_BITS     = 16;
    localparam int ROT_FRAC_MIN = 8;

    // Datapath widths, sized for the smallest rotation fraction
    localparam int SQ_BITS  = 2 * COORD_BITS;
    localparam int RP_BITS  = 2 * ROT_BITS;
    localparam int RS_BITS  = RP_BITS + 1;
    localparam int RM_BITS  = RS_BITS - ROT_FRAC_MIN + 1;
    localparam int RA_BITS  = RM_BITS - 1;
    localparam int DP_BITS  = COORD_BITS + ROT_BITS;
    localparam int DS_BITS  = DP_BITS + 1;
    localparam int EW_BITS  = DS_BITS - ROT_FRAC_MIN + 1;
    localparam int HP_BITS  = HALF_BITS + RA_BITS;
    localparam int PP_BITS  = EW_BITS + RM_BITS;
    localparam int PS_BITS  = PP_BITS + 1;
    localparam int CMP_BITS = PS_BITS + 1;

    localparam int NSTAGE = 6;

    localparam int CAUSE_BITS = 3;
    localparam logic [CAUSE_BITS-1:0] CAUSE_OVERLAP = 3'd0;
    localparam logic [CAUSE_BITS-1:0] CAUSE_FAR     = 3'd1;
    localparam logic [CAUSE_BITS-1:0] CAUSE_THIS_X  = 3'd2;
    localparam logic [CAUSE_BITS-1:0] CAUSE_THIS_Y  = 3'd3;
    localparam logic [CAUSE_BITS-1:0] CAUSE_OTHER_X = 3'd4;
    localparam logic [CAUSE_BITS-1:0] CAUSE_OTHER_Y = 3'd5;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] center_dx;
        logic signed [COORD_BITS-1:0] center_dy;
        logic [HALF_BITS-1:0]         this_half_x;
        logic [HALF_BITS-1:0]         this_half_y;
        logic [HALF_BITS-1:0]         other_half_x;
        logic [HALF_BITS-1:0]         other_half_y;
        logic signed [ROT_BITS-1:0]   this_cos;
        logic signed [ROT_BITS-1:0]   this_sin;
        logic signed [ROT_BITS-1:0]   other_cos;
        logic signed [ROT_BITS-1:0]   other_sin;
        logic [COORD_BITS-1:0]        radius_sum;
        logic                         box_mode;
    } obbsat_pair_t;

    typedef struct packed {
        logic                  colliding;
        logic [CAUSE_BITS-1:0] separation_cause;
    } obbsat_result_t;

    typedef struct packed {
        logic [NSTAGE-1:0] load;
        logic [NSTAGE-1:0] valid;
    } obbsat_ctl_t;

endpackage

@@ rtl/obbsat_pipe_ctl.sv @@
// Valid and load control for the stages of the box overlap pipeline.
`timescale 1ns / 1ps
module obbsat_pipe_ctl
    import obbsat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        upstream_valid,
    output logic        upstream_ready,
    input  logic        downstream_ready,
    output obbsat_ctl_t ctl
);

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE:0]   rdy;
    logic [NSTAGE-1:0] feed;

    // A stage may load when it is empty or its contents move on this cycle
    always_comb
    begin
        rdy[NSTAGE] = downstream_ready;
        for (int k = NSTAGE - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign feed = {valid_reg[NSTAGE-2:0], upstream_valid};

    always_comb
    begin
        for (int k = 0; k < NSTAGE; k++)
        begin
            valid_next[k] = rdy[k] ? feed[k] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign upstream_ready = rdy[0];
    assign ctl.load       = rdy[NSTAGE-1:0];
    assign ctl.valid      = valid_reg;

endmodule

@@ rtl/obb_2d_sat_collision_unit.sv @@
// Top level of the pipelined 2D oriented box overlap unit.
`timescale 1ns / 1ps
// Usage
//   pair / pair_valid / pair_ready carry one shape pair per item: centre
//   offset, half extents of both boxes, both rotations as cosine and sine
//   in Q1.ROT_FRAC_BITS, the bounding radius sum and the box mode bit.
//   result / result_valid / result_ready return one item per pair, in order:
//   colliding and the code of the first separating test.
// Timing
//   Six register stages: squares and rotation products, sums and the
//   broad-phase compare, rounding of the rotation matrix and projected
//   offset, limit and projection products, limit and projection sums, final compares.
//   One pair is accepted every cycle while the result side keeps up.
// Stalls
//   Each stage holds while it is full and the stage after it cannot take
//   its item; empty stages keep filling, so pairs are still taken while a
//   result waits on result_ready. Nothing is dropped or repeated.
// Reset
//   rst_n clears all stage valid bits; the pipeline comes up empty with
//   pair_ready high. Data registers are not reset.
module obb_2d_sat_collision_unit
    import obbsat_pkg::*;
#(
    parameter int ROT_FRAC_BITS = 14
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pair_valid,
    output logic           pair_ready,
    input  obbsat_pair_t   pair,
    output logic           result_valid,
    input  logic           result_ready,
    output obbsat_result_t result
);

    // Half an LSB for rounding half toward plus infinity
    localparam logic signed [RS_BITS-1:0] RS_HALF = RS_BITS'(1) << (ROT_FRAC_BITS - 1);
    localparam logic signed [DS_BITS-1:0] DS_HALF = DS_BITS'(1) << (ROT_FRAC_BITS - 1);

    function automatic logic signed [RM_BITS-1:0] round_rot(
        input logic signed [RS_BITS-1:0] v
    );
        logic signed [RS_BITS-1:0] s;
        logic signed [RS_BITS-1:0] q;
        s = v + RS_HALF;
        q = s >>> ROT_FRAC_BITS;
        round_rot = q[RM_BITS-1:0];
    endfunction

    function automatic logic signed [EW_BITS-1:0] round_off(
        input logic signed [DS_BITS-1:0] v
    );
        logic signed [DS_BITS-1:0] s;
        logic signed [DS_BITS-1:0] q;
        s = v + DS_HALF;
        q = s >>> ROT_FRAC_BITS;
        round_off = q[EW_BITS-1:0];
    endfunction

    function automatic logic [RA_BITS-1:0] abs_rot(input logic signed [RM_BITS-1:0] v);
        logic signed [RM_BITS-1:0] n;
        n = -v;
        abs_rot = v[RM_BITS-1] ? n[RA_BITS-1:0] : v[RA_BITS-1:0];
    endfunction

    function automatic logic [DS_BITS-1:0] abs_off(input logic signed [DS_BITS-1:0] v);
        logic signed [DS_BITS-1:0] n;
        n = -v;
        abs_off = v[DS_BITS-1] ? n : v;
    endfunction

    function automatic logic [PS_BITS-1:0] abs_proj(input logic signed [PS_BITS-1:0] v);
        logic signed [PS_BITS-1:0] n;
        n = -v;
        abs_proj = v[PS_BITS-1] ? n : v;
    endfunction

    // ------------------------------------------------------------------
    // Stage control
    // ------------------------------------------------------------------
    obbsat_ctl_t       ctl;
    logic [NSTAGE-1:0] en;

    obbsat_pipe_ctl u_pipe_ctl (
        .clk              (clk),
        .rst_n            (rst_n),
        .upstream_valid   (pair_valid),
        .upstream_ready   (pair_ready),
        .downstream_ready (result_ready),
        .ctl              (ctl)
    );

    // Load data only when a live item moves in
    assign en = ctl.load & {ctl.valid[NSTAGE-2:0], pair_valid};

    // ------------------------------------------------------------------
    // Stage 1: squares and all first-level products
    // ------------------------------------------------------------------
    logic signed [SQ_BITS-1:0] dxdx;
    logic signed [SQ_BITS-1:0] dydy;
    logic [SQ_BITS-1:0]        s1_dxdx_next, s1_dxdx_reg;
    logic [SQ_BITS-1:0]        s1_dydy_next, s1_dydy_reg;
    logic [SQ_BITS-1:0]        s1_rad2_next, s1_rad2_reg;
    logic signed [DP_BITS-1:0] s1_dxc_next, s1_dxc_reg;
    logic signed [DP_BITS-1:0] s1_dys_next, s1_dys_reg;
    logic signed [DP_BITS-1:0] s1_dyc_next, s1_dyc_reg;
    logic signed [DP_BITS-1:0] s1_dxs_next, s1_dxs_reg;
    logic signed [RP_BITS-1:0] s1_coc_next, s1_coc_reg;
    logic signed [RP_BITS-1:0] s1_sos_next, s1_sos_reg;
    logic signed [RP_BITS-1:0] s1_soc_next, s1_soc_reg;
    logic signed [RP_BITS-1:0] s1_cos_next, s1_cos_reg;
    logic [HALF_BITS-1:0]      s1_h0_reg, s1_h1_reg, s1_oh0_reg, s1_oh1_reg;
    logic                      s1_box_reg;

    always_comb
    begin
        dxdx         = SQ_BITS'(pair.center_dx) * SQ_BITS'(pair.center_dx);
        dydy         = SQ_BITS'(pair.center_dy) * SQ_BITS'(pair.center_dy);
        s1_dxdx_next = $unsigned(dxdx);
        s1_dydy_next = $unsigned(dydy);
        s1_rad2_next = SQ_BITS'(pair.radius_sum) * SQ_BITS'(pair.radius_sum);
        s1_dxc_next  = DP_BITS'(pair.center_dx) * DP_BITS'(pair.this_cos);
        s1_dys_next  = DP_BITS'(pair.center_dy) * DP_BITS'(pair.this_sin);
        s1_dyc_next  = DP_BITS'(pair.center_dy) * DP_BITS'(pair.this_cos);
        s1_dxs_next  = DP_BITS'(pair.center_dx) * DP_BITS'(pair.this_sin);
        s1_coc_next  = RP_BITS'(pair.this_cos) * RP_BITS'(pair.other_cos);
        s1_sos_next  = RP_BITS'(pair.this_sin) * RP_BITS'(pair.other_sin);
        s1_soc_next  = RP_BITS'(pair.this_sin) * RP_BITS'(pair.other_cos);
        s1_cos_next  = RP_BITS'(pair.this_cos) * RP_BITS'(pair.other_sin);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_dxdx_reg <= s1_dxdx_next;
            s1_dydy_reg <= s1_dydy_next;
            s1_rad2_reg <= s1_rad2_next;
            s1_dxc_reg  <= s1_dxc_next;
            s1_dys_reg  <= s1_dys_next;
            s1_dyc_reg  <= s1_dyc_next;
            s1_dxs_reg  <= s1_dxs_next;
            s1_coc_reg  <= s1_coc_next;
            s1_sos_reg  <= s1_sos_next;
            s1_soc_reg  <= s1_soc_next;
            s1_cos_reg  <= s1_cos_next;
            s1_h0_reg   <= pair.this_half_x;
            s1_h1_reg   <= pair.this_half_y;
            s1_oh0_reg  <= pair.other_half_x;
            s1_oh1_reg  <= pair.other_half_y;
            s1_box_reg  <= pair.box_mode;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: broad phase, projected offsets, raw rotation matrix
    // ------------------------------------------------------------------
    logic [SQ_BITS:0]          dist2;
    logic                      s2_far_next, s2_far_reg;
    logic signed [DS_BITS-1:0] s2_d0_next, s2_d0_reg;
    logic signed [DS_BITS-1:0] s2_d1_next, s2_d1_reg;
    logic signed [RS_BITS-1:0] s2_raw00_next, s2_raw00_reg;
    logic signed [RS_BITS-1:0] s2_raw01_next, s2_raw01_reg;
    logic signed [RS_BITS-1:0] s2_raw10_next, s2_raw10_reg;
    logic [HALF_BITS-1:0]      s2_h0_reg, s2_h1_reg, s2_oh0_reg, s2_oh1_reg;
    logic                      s2_box_reg;

    always_comb
    begin
        dist2         = (SQ_BITS+1)'(s1_dxdx_reg) + (SQ_BITS+1)'(s1_dydy_reg);
        // Equal distance counts as near
        s2_far_next   = dist2 > (SQ_BITS+1)'(s1_rad2_reg);
        s2_d0_next    = DS_BITS'(s1_dxc_reg) + DS_BITS'(s1_dys_reg);
        s2_d1_next    = DS_BITS'(s1_dyc_reg) - DS_BITS'(s1_dxs_reg);
        // R[1][1] equals R[0][0]; R[1][0] is rounded from the negated raw term
        s2_raw00_next = RS_BITS'(s1_coc_reg) + RS_BITS'(s1_sos_reg);
        s2_raw01_next = RS_BITS'(s1_soc_reg) - RS_BITS'(s1_cos_reg);
        s2_raw10_next = RS_BITS'(s1_cos_reg) - RS_BITS'(s1_soc_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_far_reg   <= s2_far_next;
            s2_d0_reg    <= s2_d0_next;
            s2_d1_reg    <= s2_d1_next;
            s2_raw00_reg <= s2_raw00_next;
            s2_raw01_reg <= s2_raw01_next;
            s2_raw10_reg <= s2_raw10_next;
            s2_h0_reg    <= s1_h0_reg;
            s2_h1_reg    <= s1_h1_reg;
            s2_oh0_reg   <= s1_oh0_reg;
            s2_oh1_reg   <= s1_oh1_reg;
            s2_box_reg   <= s1_box_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: round matrix and offsets, take magnitudes
    // ------------------------------------------------------------------
    logic signed [RM_BITS-1:0] s3_r00_next, s3_r00_reg;
    logic signed [RM_BITS-1:0] s3_r01_next, s3_r01_reg;
    logic signed [RM_BITS-1:0] s3_r10_next, s3_r10_reg;
    logic [RA_BITS-1:0]        s3_a00_reg, s3_a01_reg, s3_a10_reg;
    logic signed [EW_BITS-1:0] s3_e0_reg, s3_e1_reg;
    logic [DS_BITS-1:0]        s3_ad0_reg, s3_ad1_reg;
    logic [HALF_BITS-1:0]      s3_h0_reg, s3_h1_reg, s3_oh0_reg, s3_oh1_reg;
    logic                      s3_far_reg, s3_box_reg;

    always_comb
    begin
        s3_r00_next = round_rot(s2_raw00_reg);
        s3_r01_next = round_rot(s2_raw01_reg);
        s3_r10_next = round_rot(s2_raw10_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_r00_reg <= s3_r00_next;
            s3_r01_reg <= s3_r01_next;
            s3_r10_reg <= s3_r10_next;
            s3_a00_reg <= abs_rot(s3_r00_next);
            s3_a01_reg <= abs_rot(s3_r01_next);
            s3_a10_reg <= abs_rot(s3_r10_next);
            s3_e0_reg  <= round_off(s2_d0_reg);
            s3_e1_reg  <= round_off(s2_d1_reg);
            s3_ad0_reg <= abs_off(s2_d0_reg);
            s3_ad1_reg <= abs_off(s2_d1_reg);
            s3_h0_reg  <= s2_h0_reg;
            s3_h1_reg  <= s2_h1_reg;
            s3_oh0_reg <= s2_oh0_reg;
            s3_oh1_reg <= s2_oh1_reg;
            s3_far_reg <= s2_far_reg;
            s3_box_reg <= s2_box_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: half-extent and projection products
    // ------------------------------------------------------------------
    logic [HP_BITS-1:0]        s4_t00_next, s4_t00_reg, s4_t01_next, s4_t01_reg;
    logic [HP_BITS-1:0]        s4_t10_next, s4_t10_reg, s4_t11_next, s4_t11_reg;
    logic [HP_BITS-1:0]        s4_u00_next, s4_u00_reg, s4_u10_next, s4_u10_reg;
    logic [HP_BITS-1:0]        s4_u01_next, s4_u01_reg, s4_u11_next, s4_u11_reg;
    logic signed [PP_BITS-1:0] s4_p00_next, s4_p00_reg, s4_p10_next, s4_p10_reg;
    logic signed [PP_BITS-1:0] s4_p01_next, s4_p01_reg, s4_p11_next, s4_p11_reg;
    logic [DS_BITS-1:0]        s4_ad0_reg, s4_ad1_reg;
    logic [HALF_BITS-1:0]      s4_h0_reg, s4_h1_reg, s4_oh0_reg, s4_oh1_reg;
    logic                      s4_far_reg, s4_box_reg;

    always_comb
    begin
        // other extents projected on this box's axes
        s4_t00_next = HP_BITS'(s3_oh0_reg) * HP_BITS'(s3_a00_reg);
        s4_t01_next = HP_BITS'(s3_oh1_reg) * HP_BITS'(s3_a01_reg);
        s4_t10_next = HP_BITS'(s3_oh0_reg) * HP_BITS'(s3_a10_reg);
        s4_t11_next = HP_BITS'(s3_oh1_reg) * HP_BITS'(s3_a00_reg);
        // this box's extents projected on the other box's axes
        s4_u00_next = HP_BITS'(s3_h0_reg) * HP_BITS'(s3_a00_reg);
        s4_u10_next = HP_BITS'(s3_h1_reg) * HP_BITS'(s3_a10_reg);
        s4_u01_next = HP_BITS'(s3_h0_reg) * HP_BITS'(s3_a01_reg);
        s4_u11_next = HP_BITS'(s3_h1_reg) * HP_BITS'(s3_a00_reg);
        // rounded offset rotated onto the other box's axes
        s4_p00_next = PP_BITS'(s3_e0_reg) * PP_BITS'(s3_r00_reg);
        s4_p10_next = PP_BITS'(s3_e1_reg) * PP_BITS'(s3_r10_reg);
        s4_p01_next = PP_BITS'(s3_e0_reg) * PP_BITS'(s3_r01_reg);
        s4_p11_next = PP_BITS'(s3_e1_reg) * PP_BITS'(s3_r00_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_t00_reg <= s4_t00_next;
            s4_t01_reg <= s4_t01_next;
            s4_t10_reg <= s4_t10_next;
            s4_t11_reg <= s4_t11_next;
            s4_u00_reg <= s4_u00_next;
            s4_u10_reg <= s4_u10_next;
            s4_u01_reg <= s4_u01_next;
            s4_u11_reg <= s4_u11_next;
            s4_p00_reg <= s4_p00_next;
            s4_p10_reg <= s4_p10_next;
            s4_p01_reg <= s4_p01_next;
            s4_p11_reg <= s4_p11_next;
            s4_ad0_reg <= s3_ad0_reg;
            s4_ad1_reg <= s3_ad1_reg;
            s4_h0_reg  <= s3_h0_reg;
            s4_h1_reg  <= s3_h1_reg;
            s4_oh0_reg <= s3_oh0_reg;
            s4_oh1_reg <= s3_oh1_reg;
            s4_far_reg <= s3_far_reg;
            s4_box_reg <= s3_box_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: limit and projection sums
    // ------------------------------------------------------------------
    logic [CMP_BITS-1:0]       s5_lima0_next, s5_lima0_reg, s5_lima1_next, s5_lima1_reg;
    logic [CMP_BITS-1:0]       s5_limb0_next, s5_limb0_reg, s5_limb1_next, s5_limb1_reg;
    logic signed [PS_BITS-1:0] s5_proj0_next, s5_proj0_reg, s5_proj1_next, s5_proj1_reg;
    logic [DS_BITS-1:0]        s5_ad0_reg, s5_ad1_reg;
    logic                      s5_far_reg, s5_box_reg;

    always_comb
    begin
        s5_lima0_next = (CMP_BITS'(s4_h0_reg) << ROT_FRAC_BITS)
                      + CMP_BITS'(s4_t00_reg) + CMP_BITS'(s4_t01_reg);
        s5_lima1_next = (CMP_BITS'(s4_h1_reg) << ROT_FRAC_BITS)
                      + CMP_BITS'(s4_t10_reg) + CMP_BITS'(s4_t11_reg);
        s5_limb0_next = (CMP_BITS'(s4_oh0_reg) << ROT_FRAC_BITS)
                      + CMP_BITS'(s4_u00_reg) + CMP_BITS'(s4_u10_reg);
        s5_limb1_next = (CMP_BITS'(s4_oh1_reg) << ROT_FRAC_BITS)
                      + CMP_BITS'(s4_u01_reg) + CMP_BITS'(s4_u11_reg);
        s5_proj0_next = PS_BITS'(s4_p00_reg) + PS_BITS'(s4_p10_reg);
        s5_proj1_next = PS_BITS'(s4_p01_reg) + PS_BITS'(s4_p11_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s5_lima0_reg <= s5_lima0_next;
            s5_lima1_reg <= s5_lima1_next;
            s5_limb0_reg <= s5_limb0_next;
            s5_limb1_reg <= s5_limb1_next;
            s5_proj0_reg <= s5_proj0_next;
            s5_proj1_reg <= s5_proj1_next;
            s5_ad0_reg   <= s4_ad0_reg;
            s5_ad1_reg   <= s4_ad1_reg;
            s5_far_reg   <= s4_far_reg;
            s5_box_reg   <= s4_box_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: axis compares and first-hit select into the output register
    // ------------------------------------------------------------------
    logic           sep_a0, sep_a1, sep_b0, sep_b1;
    obbsat_result_t result_next, result_reg;

    always_comb
    begin
        // Touching boxes do not separate: strict compare
        sep_a0 = CMP_BITS'(s5_ad0_reg) > s5_lima0_reg;
        sep_a1 = CMP_BITS'(s5_ad1_reg) > s5_lima1_reg;
        sep_b0 = CMP_BITS'(abs_proj(s5_proj0_reg)) > s5_limb0_reg;
        sep_b1 = CMP_BITS'(abs_proj(s5_proj1_reg)) > s5_limb1_reg;

        result_next.colliding        = 1'b0;
        result_next.separation_cause = CAUSE_OVERLAP;
        if (s5_far_reg)
        begin
            result_next.separation_cause = CAUSE_FAR;
        end
        else if (!s5_box_reg)
        begin
            result_next.colliding = 1'b1;
        end
        else if (sep_a0)
        begin
            result_next.separation_cause = CAUSE_THIS_X;
        end
        else if (sep_a1)
        begin
            result_next.separation_cause = CAUSE_THIS_Y;
        end
        else if (sep_b0)
        begin
            result_next.separation_cause = CAUSE_OTHER_X;
        end
        else if (sep_b1)
        begin
            result_next.separation_cause = CAUSE_OTHER_Y;
        end
        else
        begin
            result_next.colliding = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            result_reg <= result_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = ctl.valid[NSTAGE-1];

endmodule

@@ rtl/obbsat_chk.sv @@
// Port-level checks for the box overlap unit, with the bind to the top level.
`timescale 1ns / 1ps
`include "obb_2d_sat_collision_unit_macros.svh"
module obbsat_chk
    import obbsat_pkg::*;
(
    input logic           clk,
    input logic           rst_n,
    input logic           pair_valid,
    input logic           pair_ready,
    input logic           result_valid,
    input logic           result_ready,
    input obbsat_result_t result
);

    localparam int FLIGHT_BITS = $clog2(NSTAGE + 2);
    localparam logic [FLIGHT_BITS-1:0] FLIGHT_MAX = FLIGHT_BITS'(NSTAGE);

    logic [FLIGHT_BITS-1:0] inflight_reg;
    logic [FLIGHT_BITS-1:0] inflight_next;
    logic                   take_in;
    logic                   take_out;
    logic                   overlap_code;

    assign take_in      = pair_valid && pair_ready;
    assign take_out     = result_valid && result_ready;
    assign overlap_code = (result.separation_cause == CAUSE_OVERLAP);

    // Track items accepted but not yet delivered
    always_comb
    begin
        inflight_next = inflight_reg + FLIGHT_BITS'(take_in) - FLIGHT_BITS'(take_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    `OBBSAT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))
    `OBBSAT_IMPLIES(a_cause_match, result_valid, result.colliding == overlap_code)
    `OBBSAT_IMPLIES(a_no_ghost, result_valid, inflight_reg != '0)
    `OBBSAT_ASSERT(a_depth, inflight_reg <= FLIGHT_MAX)
    `OBBSAT_IMPLIES(a_empty_ready, inflight_reg == '0, pair_ready)

endmodule

bind obb_2d_sat_collision_unit obbsat_chk u_obbsat_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .pair_valid   (pair_valid),
    .pair_ready   (pair_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

@@ sim/obb_2d_sat_collision_checker.sv @@
// Checker for the box overlap unit: predicts each result item and compares it on arrival.
`timescale 1ns / 1ps
module obb_2d_sat_collision_checker
    import obbsat_pkg::*;
#(
    parameter int ROT_FRAC_BITS = 14
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pair_valid,
    input  logic           pair_ready,
    input  obbsat_pair_t   pair,
    input  logic           result_valid,
    input  logic           result_ready,
    input  obbsat_result_t result,
    output int             failures,
    output int             outstanding,
    output int             pairs_accepted,
    output int             results_checked,
    output int             axis_tests,
    output int             axis_splits
);

    obbsat_result_t contact_q[$];
    obbsat_result_t want;

    // Round half toward plus infinity, dropping the rotation fraction.
    function automatic longint round_rot(input longint x);
        return (x + (longint'(1) <<< (ROT_FRAC_BITS - 1))) >>> ROT_FRAC_BITS;
    endfunction

    function automatic longint mag(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic obbsat_result_t predict_contact(input obbsat_pair_t p);
        longint dx;
        longint dy;
        longint rad;
        longint lim;
        longint proj;
        longint unit;
        longint this_half [2];
        longint other_half [2];
        longint ax [2];
        longint ay [2];
        longint bx [2];
        longint by [2];
        longint rot [2][2];
        longint dproj [2];
        longint eproj [2];
        obbsat_result_t r;
        int i;
        int j;
        unit = longint'(1) <<< ROT_FRAC_BITS;
        dx = longint'($signed(p.center_dx));
        dy = longint'($signed(p.center_dy));
        this_half[0] = longint'(p.this_half_x);
        this_half[1] = longint'(p.this_half_y);
        other_half[0] = longint'(p.other_half_x);
        other_half[1] = longint'(p.other_half_y);
        ax[0] = longint'($signed(p.this_cos));
        ay[0] = longint'($signed(p.this_sin));
        ax[1] = -ay[0];
        ay[1] = ax[0];
        bx[0] = longint'($signed(p.other_cos));
        by[0] = longint'($signed(p.other_sin));
        bx[1] = -by[0];
        by[1] = bx[0];
        rad = longint'(p.radius_sum);
        r.colliding = 1'b1;
        r.separation_cause = CAUSE_OVERLAP;
        if (dx * dx + dy * dy > rad * rad)
        begin
            r.colliding = 1'b0;
            r.separation_cause = CAUSE_FAR;
            return r;
        end
        if (!p.box_mode)
            return r;
        for (i = 0; i < 2; i++)
        begin
            for (j = 0; j < 2; j++)
                rot[i][j] = round_rot(ax[i] * bx[j] + ay[i] * by[j]);
            dproj[i] = dx * ax[i] + dy * ay[i];
            eproj[i] = round_rot(dproj[i]);
        end
        for (i = 0; i < 2; i++)
        begin
            lim = this_half[i] * unit + other_half[0] * mag(rot[i][0])
                + other_half[1] * mag(rot[i][1]);
            if (mag(dproj[i]) > lim)
            begin
                r.colliding = 1'b0;
                r.separation_cause = (i == 0) ? CAUSE_THIS_X : CAUSE_THIS_Y;
                return r;
            end
        end
        for (i = 0; i < 2; i++)
        begin
            proj = eproj[0] * rot[0][i] + eproj[1] * rot[1][i];
            lim = this_half[0] * mag(rot[0][i]) + this_half[1] * mag(rot[1][i])
                + other_half[i] * unit;
            if (mag(proj) > lim)
            begin
                r.colliding = 1'b0;
                r.separation_cause = (i == 0) ? CAUSE_OTHER_X : CAUSE_OTHER_Y;
                return r;
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            contact_q.delete();
            failures = 0;
            outstanding = 0;
            pairs_accepted = 0;
            results_checked = 0;
            axis_tests = 0;
            axis_splits = 0;
        end
        else
        begin
            // Retire first so a result never meets the pair taken at the same edge.
            if (result_valid && result_ready)
            begin
                if (contact_q.size() == 0)
                begin
                    $error("result item with no pair waiting: colliding %0d cause %0d",
                           result.colliding, result.separation_cause);
                    failures++;
                end
                else
                begin
                    want = contact_q.pop_front();
                    if (result.colliding !== want.colliding)
                    begin
                        $error("colliding: expected %0d, actual %0d",
                               want.colliding, result.colliding);
                        failures++;
                    end
                    if (result.separation_cause !== want.separation_cause)
                    begin
                        $error("separation_cause: expected %0d, actual %0d",
                               want.separation_cause, result.separation_cause);
                        failures++;
                    end
                    results_checked++;
                end
            end
            if (pair_valid && pair_ready)
            begin
                want = predict_contact(pair);
                contact_q.push_back(want);
                pairs_accepted++;
                if (pair.box_mode && want.separation_cause != CAUSE_FAR)
                    axis_tests++;
                if (want.separation_cause != CAUSE_FAR
                    && want.separation_cause != CAUSE_OVERLAP)
                    axis_splits++;
            end
            outstanding = contact_q.size();
        end
    end

endmodule

@@ sim/tb_obb_2d_sat_collision_unit.sv @@
// Testbench top for the box overlap unit: stimulus, result-side stalls and verdict.
`timescale 1ns / 1ps
module tb_obb_2d_sat_collision_unit;
    import obbsat_pkg::*;

    localparam int ROT_FRAC_BITS = 14;

    // Fixed-point reference points: one coordinate unit, one rotation unit, 45 degrees.
    localparam int Q_ONE   = 256;
    localparam int ROT_ONE = 16384;
    localparam int ROT_45  = 11585;
    localparam int MAX_COORD = 8388607;
    localparam int MIN_COORD = -8388608;
    localparam int MAX_HALF  = 8388607;
    localparam int MAX_RAD   = 16777215;
    localparam int MIN_ROT   = -32768;
    localparam int MAX_ROT   = 32767;

    // Run shape.
    localparam int RANDOM_ITEMS = 1080;
    localparam int TAIL_ITEMS   = 150;
    localparam int DRAIN_AT     = 500;
    localparam int HOLD_AT      = 400;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_PAIRS   = RANDOM_ITEMS - TAIL_ITEMS;
    localparam int CYCLE_LIMIT  = 400000;

    logic           clk;
    logic           rst_n;
    logic           pair_valid;
    logic           pair_ready;
    obbsat_pair_t   pair;
    logic           result_valid;
    logic           result_ready;
    obbsat_result_t result;

    int failures;
    int outstanding;
    int pairs_accepted;
    int results_checked;
    int axis_tests;
    int axis_splits;
    int cycle_count;

    obb_2d_sat_collision_unit #(
        .ROT_FRAC_BITS (ROT_FRAC_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_valid   (pair_valid),
        .pair_ready   (pair_ready),
        .pair         (pair),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // The checker only watches both channels; it never drives the block.
    obb_2d_sat_collision_checker #(
        .ROT_FRAC_BITS (ROT_FRAC_BITS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .pair_valid      (pair_valid),
        .pair_ready      (pair_ready),
        .pair            (pair),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result          (result),
        .failures        (failures),
        .outstanding     (outstanding),
        .pairs_accepted  (pairs_accepted),
        .results_checked (results_checked),
        .axis_tests      (axis_tests),
        .axis_splits     (axis_splits)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: a hung handshake or a lost result ends up here.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Build one pair item from plain integers; fields take their low bits.
    function automatic obbsat_pair_t make_pair(input int dx, input int dy,
                                               input int hx, input int hy,
                                               input int ohx, input int ohy,
                                               input int c, input int s,
                                               input int oc, input int os,
                                               input int rad, input bit box);
        obbsat_pair_t p;
        p.center_dx    = COORD_BITS'(dx);
        p.center_dy    = COORD_BITS'(dy);
        p.this_half_x  = HALF_BITS'(hx);
        p.this_half_y  = HALF_BITS'(hy);
        p.other_half_x = HALF_BITS'(ohx);
        p.other_half_y = HALF_BITS'(ohy);
        p.this_cos     = ROT_BITS'(c);
        p.this_sin     = ROT_BITS'(s);
        p.other_cos    = ROT_BITS'(oc);
        p.other_sin    = ROT_BITS'(os);
        p.radius_sum   = COORD_BITS'(rad);
        p.box_mode     = box;
        return p;
    endfunction

    // Half proper rotations; the rest arbitrary in-range or raw 16-bit values, a quarter each.
    task automatic random_rotation(output logic signed [ROT_BITS-1:0] c,
                                   output logic signed [ROT_BITS-1:0] s);
        real ang;
        int  mode;
        mode = $urandom_range(0, 3);
        if (mode < 2)
        begin
            ang = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
            c = ROT_BITS'($rtoi($cos(ang) * ROT_ONE));
            s = ROT_BITS'($rtoi($sin(ang) * ROT_ONE));
        end
        else if (mode == 2)
        begin
            c = ROT_BITS'(int'($urandom_range(0, 2 * ROT_ONE)) - ROT_ONE);
            s = ROT_BITS'(int'($urandom_range(0, 2 * ROT_ONE)) - ROT_ONE);
        end
        else
        begin
            c = ROT_BITS'($urandom);
            s = ROT_BITS'($urandom);
        end
    endtask

    // Near pairs at a random scale reach the axis test; a tenth is raw noise.
    task automatic random_pair(output obbsat_pair_t p);
        int         span;
        logic [255:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom};
        p = noise[$bits(obbsat_pair_t)-1:0];
        if ($urandom_range(0, 9) != 0)
        begin
            span = 1 << $urandom_range(4, 21);
            p.center_dx    = COORD_BITS'(int'($urandom_range(0, 2 * span)) - span);
            p.center_dy    = COORD_BITS'(int'($urandom_range(0, 2 * span)) - span);
            p.this_half_x  = HALF_BITS'($urandom_range(0, span));
            p.this_half_y  = HALF_BITS'($urandom_range(0, span));
            p.other_half_x = HALF_BITS'($urandom_range(0, span));
            p.other_half_y = HALF_BITS'($urandom_range(0, span));
            p.radius_sum   = COORD_BITS'($urandom_range(0, 4 * span));
            p.box_mode     = ($urandom_range(0, 4) != 0);
            random_rotation(p.this_cos, p.this_sin);
            random_rotation(p.other_cos, p.other_sin);
        end
    endtask

    // Offer one item after an optional idle gap and hold it until accepted.
    task automatic offer_pair(input obbsat_pair_t p, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            pair_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        pair       <= p;
        pair_valid <= 1'b1;
        @(posedge clk);
        while (!pair_ready) @(posedge clk);
    endtask

    // Drop valid and hold off until every predicted result has come back.
    task automatic wait_drained();
        @(negedge clk);
        pair_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    // Result side: random stall bursts, one long hold-off once the pipe is busy,
    // and a steady ready through the tail of the run.
    initial
    begin : result_side
        bit long_hold_done;
        long_hold_done = 1'b0;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && pairs_accepted >= HOLD_AT)
            begin
                long_hold_done = 1'b1;
                result_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (pairs_accepted < TAIL_PAIRS && $urandom_range(0, 7) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge clk);
            end
            else
                result_ready <= 1'b1;
        end
    end

    initial
    begin : pair_side
        obbsat_pair_t p;
        int gap;
        int i;
        rst_n = 1'b0;
        pair_valid = 1'b0;
        pair = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: field extremes, the distance boundary, touching boxes,
        // every separating axis and rotations that are not unit length.
        offer_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0), 0);
        offer_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), 0);
        offer_pair(make_pair(MAX_COORD, MAX_COORD, 0, 0, 0, 0,
                             ROT_ONE, 0, ROT_ONE, 0, 0, 1'b1), 0);
        offer_pair(make_pair(MIN_COORD, MIN_COORD, 0, 0, 0, 0,
                             ROT_ONE, 0, ROT_ONE, 0, MAX_RAD, 1'b0), 0);
        offer_pair(make_pair(MIN_COORD, MAX_COORD, MAX_HALF, MAX_HALF, MAX_HALF, MAX_HALF,
                             ROT_ONE, 0, ROT_ONE, 0, MAX_RAD, 1'b1), 0);
        offer_pair(make_pair(3 * Q_ONE, 4 * Q_ONE, 0, 0, 0, 0,
                             ROT_ONE, 0, ROT_ONE, 0, 5 * Q_ONE, 1'b0), 0);
        offer_pair(make_pair(3 * Q_ONE, 4 * Q_ONE, 0, 0, 0, 0,
                             ROT_ONE, 0, ROT_ONE, 0, 5 * Q_ONE - 1, 1'b0), 0);
        offer_pair(make_pair(3 * Q_ONE, -4 * Q_ONE, 4 * Q_ONE, 4 * Q_ONE, Q_ONE, Q_ONE,
                             ROT_ONE, 0, ROT_ONE, 0, 5 * Q_ONE, 1'b1), 0);
        // Touching along this x axis, just past it on either side, then touching and just past along y.
        offer_pair(make_pair(2 * Q_ONE, 0, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                             ROT_ONE, 0, ROT_ONE, 0, MAX_RAD, 1'b1), 0);
        offer_pair(make_pair(2 * Q_ONE + 1, 0, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                             ROT_ONE, 0, ROT_ONE, 0, MAX_RAD, 1'b1), 0);
        offer_pair(make_pair(-2 * Q_ONE - 1, 0, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                             ROT_ONE, 0, ROT_ONE, 0, MAX_RAD, 1'b1), 0);
        offer_pair(make_pair(0, -2 * Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                             ROT_ONE, 0, ROT_ONE, 0, MAX_RAD, 1'b1), 0);
        offer_pair(make_pair(0, 2 * Q_ONE + 1, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                             ROT_ONE, 0, ROT_ONE, 0, MAX_RAD, 1'b1), 0);
        // Thin diagonal other box: only its own axes can separate.
        offer_pair(make_pair(2 * Q_ONE, 2 * Q_ONE, Q_ONE, Q_ONE, 26, 10 * Q_ONE,
                             ROT_ONE, 0, ROT_45, ROT_45, MAX_RAD, 1'b1), 0);
        offer_pair(make_pair(2 * Q_ONE, -2 * Q_ONE, Q_ONE, Q_ONE, 10 * Q_ONE, 26,
                             ROT_ONE, 0, ROT_45, ROT_45, MAX_RAD, 1'b1), 0);
        offer_pair(make_pair(5 * Q_ONE, -3 * Q_ONE, 2 * Q_ONE, Q_ONE, Q_ONE, 3 * Q_ONE,
                             MIN_ROT, MIN_ROT, MIN_ROT, MIN_ROT, MAX_RAD, 1'b1), 0);
        offer_pair(make_pair(-7 * Q_ONE, 6 * Q_ONE, 3 * Q_ONE, 2 * Q_ONE, Q_ONE, 4 * Q_ONE,
                             ROT_ONE, ROT_ONE, -ROT_ONE, -ROT_ONE, MAX_RAD, 1'b1), 0);
        offer_pair(make_pair(MIN_COORD, 0, MAX_HALF, 0, 0, MAX_HALF,
                             MAX_ROT, MIN_ROT, MIN_ROT, MAX_ROT, MAX_RAD, 1'b1), 0);
        offer_pair(make_pair(MIN_COORD, MIN_COORD, MAX_HALF, MAX_HALF, MAX_HALF, MAX_HALF,
                             ROT_45, -ROT_45, 0, ROT_ONE, 1, 1'b1), 0);
        wait_drained();

        // Random part: bursts of idle on the pair side until the tail.
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == DRAIN_AT)
                wait_drained();
            random_pair(p);
            gap = 0;
            if (i < TAIL_PAIRS && $urandom_range(0, 4) == 0)
                gap = $urandom_range(1, 19);
            offer_pair(p, gap);
        end
        @(negedge clk);
        pair_valid <= 1'b0;

        // Let the last results come back, then give the pipe time to show strays.
        while (outstanding != 0) @(negedge clk);
        repeat (2 * NSTAGE) @(negedge clk);

        $display("Covered %0d pairs, %0d box axis tests, %0d split by an axis.",
                 results_checked, axis_tests, axis_splits);
        $display("Stimulus held directed edge cases, a long result stall and a drain pause.");
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
